FILE: design/acre_pkg.sv
// Shared types and constants for the adaptive context range encoder.
// Used by the channel interfaces, the front queue, the coding engine and the top level.
package acre_pkg;

  // Fixed field widths of the channels.
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;

  // Model storage widths.
  localparam int FREQ_W  = 16;
  localparam int TOTAL_W = 17;

  // Default configuration.
  localparam int DEF_SYMBOL_BITS = 8;
  localparam int DEF_MODEL_ORDER = 1;

  // Coder constants.
  localparam logic [31:0] RANGE_TOP   = 32'h0100_0000;
  localparam logic [31:0] RANGE_BOT   = 32'h0001_0000;
  localparam logic [31:0] RANGE_FULL  = 32'hFFFF_FFFF;
  localparam logic [31:0] LOW_MASK    = 32'h0000_FFFF;
  localparam logic [16:0] STEP_INC    = 17'd32;
  localparam logic [17:0] TOTAL_LIMIT = 18'h0FFFF;
  localparam int          MAX_RENORM  = 4;
  localparam int          FLUSH_BYTES = 4;

  // One queued symbol request.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_last;
  } item_t;

endpackage

FILE: design/acre_sym_if.sv
// Symbol request channel: valid/ready handshake with symbol and end-of-stream flag.
// Depends on acre_pkg for the field width.
interface acre_sym_if;
  import acre_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink (input valid, input symbol, input is_last, output ready);
endinterface

FILE: design/acre_byte_if.sv
// Coded byte channel: valid/ready handshake with one byte and a last-of-run flag.
// Depends on acre_pkg for the field width.
interface acre_byte_if;
  import acre_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: design/acre_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module acre_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/acre_front.sv
// Front end: accepts symbol requests, trims the symbol to the alphabet and queues them.
// Depends on acre_pkg and acre_sym_if.
module acre_front #(
  parameter int SYMBOL_BITS = acre_pkg::DEF_SYMBOL_BITS
) (
  input  logic            clk,
  input  logic            rst,
  acre_sym_if.sink        sym_ch,
  input  logic            clearing,
  output logic            q_valid,
  output acre_pkg::item_t q_item,
  input  logic            pop
);
  import acre_pkg::*;

  localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((1 << SYMBOL_BITS) - 1);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // No requests are taken while the model tables are being cleared.
  assign sym_ch.ready = !clearing && (count != 2'd2);
  assign push         = sym_ch.valid && sym_ch.ready;
  assign q_valid      = (count != 2'd0);
  assign q_item       = slots[rd_ptr];

  // Two-entry queue between the handshake and the coding engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr].symbol  <= sym_ch.symbol & SYM_MASK;
        slots[wr_ptr].is_last <= sym_ch.is_last;
        wr_ptr                <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");
  a_no_push_clear: assert property (@(posedge clk) disable iff (rst) clearing |-> !push)
    else $error("request taken during table clearing");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |=> (count != 2'd0))
    else $error("queue count jumped from full to empty");

endmodule

FILE: design/acre_engine.sv
// Back end: table clearing, model lookup, range division, renormalization, model update and flush.
// Depends on acre_pkg, acre_byte_if and acre_ram.
module acre_engine #(
  parameter int SYMBOL_BITS = acre_pkg::DEF_SYMBOL_BITS,
  parameter int MODEL_ORDER = acre_pkg::DEF_MODEL_ORDER
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  acre_pkg::item_t q_item,
  output logic            pop,
  output logic            clearing,
  acre_byte_if.source     byte_ch
);
  import acre_pkg::*;

  localparam int SB = SYMBOL_BITS;
  localparam int FA = SYMBOL_BITS * (MODEL_ORDER + 1);
  localparam int FD = 1 << FA;
  localparam int CA = (SYMBOL_BITS * MODEL_ORDER > 0) ? SYMBOL_BITS * MODEL_ORDER : 1;
  localparam int CD = 1 << (SYMBOL_BITS * MODEL_ORDER);
  localparam logic [TOTAL_W-1:0] NUM_SYM = TOTAL_W'(1 << SYMBOL_BITS);
  localparam logic [SB-1:0]      LAST_SYM = '1;
  localparam logic [FA-1:0]      LAST_ADDR = '1;

  typedef enum logic [10:0] {
    ST_CLEAR   = 11'b000_0000_0001,
    ST_IDLE    = 11'b000_0000_0010,
    ST_WALK    = 11'b000_0000_0100,
    ST_DIV     = 11'b000_0000_1000,
    ST_MUL     = 11'b000_0001_0000,
    ST_ADD     = 11'b000_0010_0000,
    ST_RENORM  = 11'b000_0100_0000,
    ST_UPDATE  = 11'b000_1000_0000,
    ST_RESCALE = 11'b001_0000_0000,
    ST_FLUSH   = 11'b010_0000_0000,
    ST_FINISH  = 11'b100_0000_0000
  } state_t;

  state_t             state;
  logic [FA-1:0]      clr_idx;
  logic [SB-1:0]      ctx;
  logic [SB-1:0]      sym;
  logic               last;
  logic [SB:0]        j;
  logic [SB-1:0]      pj;
  logic               pv;
  logic [23:0]        start;
  logic [FREQ_W-1:0]  size;
  logic [TOTAL_W-1:0] tot_raw;
  logic [TOTAL_W-1:0] tot;
  logic [TOTAL_W-1:0] rem;
  logic [31:0]        quo;
  logic [4:0]         dcnt;
  logic [31:0]        low;
  logic [31:0]        range;
  logic [31:0]        prod;
  logic [2:0]         k;
  logic [TOTAL_W-1:0] sum;
  logic               hold_valid;
  logic [7:0]         hold_byte;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;

  // RAM ports.
  logic               f_we;
  logic [FA-1:0]      f_wa;
  logic [FREQ_W-1:0]  f_wd;
  logic [FA-1:0]      f_ra;
  logic [FREQ_W-1:0]  f_rd;
  logic               t_we;
  logic [CA-1:0]      t_wa;
  logic [TOTAL_W-1:0] t_wd;
  logic [TOTAL_W-1:0] t_rd;

  // Datapath helpers.
  logic [TOTAL_W:0]   trial;
  logic               q_bit;
  logic [55:0]        p_low;
  logic [47:0]        p_range;
  logic [16:0]        f_inc;
  logic [17:0]        t_inc;
  logic               rescale;
  logic [16:0]        r_src;
  logic [15:0]        r_half;
  logic [FREQ_W-1:0]  r_val;
  logic [TOTAL_W-1:0] sum_new;
  logic [31:0]        low_add;
  logic               close;
  logic               tiny;
  logic               can_push;
  logic               emit_ok;
  logic               out_load;

  function automatic logic [FA-1:0] faddr(input logic [SB-1:0] c, input logic [SB-1:0] i);
    logic [2*SB-1:0] cat;
    cat = {c, i};
    return cat[FA-1:0];
  endfunction

  acre_ram #(.WIDTH(FREQ_W), .DEPTH(FD)) u_freq (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );

  acre_ram #(.WIDTH(TOTAL_W), .DEPTH(CD)) u_total (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(ctx[CA-1:0]), .rdata(t_rd)
  );

  // Arithmetic for the current step.
  always_comb begin
    trial    = {rem, quo[31]};
    q_bit    = (trial >= {1'b0, tot});
    p_low    = 56'(start) * 56'(quo);
    p_range  = 48'(quo) * 48'(size);
    f_inc    = {1'b0, size} + STEP_INC;
    t_inc    = {1'b0, tot_raw} + {1'b0, STEP_INC};
    rescale  = (t_inc >= TOTAL_LIMIT);
    r_src    = (pj == sym) ? f_inc : {1'b0, f_rd};
    r_half   = r_src[16:1];
    r_val    = (r_half == 16'd0) ? 16'd1 : r_half;
    sum_new  = sum + TOTAL_W'(r_val);
    low_add  = low + range;
    close    = ((low ^ low_add) < RANGE_TOP);
    tiny     = (range < RANGE_BOT);
    can_push = !out_valid || byte_ch.ready;
    emit_ok  = !hold_valid || can_push;
    // The held byte moves to the output register in this cycle.
    out_load = hold_valid && can_push &&
               (((state == ST_RENORM) && (k != 3'(MAX_RENORM)) && (close || tiny)) ||
                ((state == ST_FLUSH) && (k != 3'(FLUSH_BYTES))) ||
                (state == ST_FINISH));
  end

  // Table port control.
  always_comb begin
    f_ra = faddr(ctx, j[SB-1:0]);
    f_we = 1'b0;
    f_wa = faddr(ctx, sym);
    f_wd = f_inc[FREQ_W-1:0];
    t_we = 1'b0;
    t_wa = ctx[CA-1:0];
    t_wd = t_inc[TOTAL_W-1:0];
    pop  = 1'b0;
    if (state == ST_CLEAR) begin
      f_we = 1'b1;
      f_wa = clr_idx;
      f_wd = FREQ_W'(1);
      t_we = 1'b1;
      t_wa = clr_idx[CA-1:0];
      t_wd = NUM_SYM;
    end else if (state == ST_IDLE) begin
      pop = q_valid;
    end else if (state == ST_UPDATE) begin
      f_we = !rescale;
      t_we = !rescale;
    end else if (state == ST_RESCALE) begin
      f_we = pv;
      f_wa = faddr(ctx, pj);
      f_wd = r_val;
      t_we = pv && (pj == LAST_SYM);
      t_wd = sum_new;
    end
  end

  assign clearing          = (state == ST_CLEAR);
  assign byte_ch.valid       = out_valid;
  assign byte_ch.out_byte    = out_byte;
  assign byte_ch.last_of_run = out_last;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      ctx        <= '0;
      low        <= '0;
      range      <= RANGE_FULL;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      pv         <= 1'b0;
    end else begin
      if (out_valid && byte_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + FA'(1);
          if (clr_idx == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            sym   <= q_item.symbol[SB-1:0];
            last  <= q_item.is_last;
            start <= '0;
            j     <= '0;
            pv    <= 1'b0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          // Reads run one ahead of the running sum.
          j  <= j + 1'b1;
          pj <= j[SB-1:0];
          pv <= 1'b1;
          if (pv) begin
            if (pj == sym) begin
              size    <= f_rd;
              tot_raw <= t_rd;
              tot     <= (t_rd == '0) ? TOTAL_W'(1) : t_rd;
              quo     <= range;
              rem     <= '0;
              dcnt    <= '0;
              state   <= ST_DIV;
            end else begin
              start <= start + 24'(f_rd);
            end
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          rem  <= q_bit ? TOTAL_W'(trial - {1'b0, tot}) : trial[TOTAL_W-1:0];
          quo  <= {quo[30:0], q_bit};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= p_low[31:0];
          range <= p_range[31:0];
          state <= ST_ADD;
        end
        ST_ADD: begin
          low   <= low + prod;
          k     <= '0;
          state <= ST_RENORM;
        end
        ST_RENORM: begin
          if ((k == 3'(MAX_RENORM)) || (!close && !tiny)) begin
            state <= ST_UPDATE;
          end else if (emit_ok) begin
            if (tiny && !close) begin
              range <= ((32'd0 - low) & LOW_MASK) << 8;
            end else begin
              range <= range << 8;
            end
            low        <= low << 8;
            k          <= k + 3'd1;
            hold_byte  <= low[31:24];
            hold_valid <= 1'b1;
            if (hold_valid) begin
              out_valid <= 1'b1;
              out_byte  <= hold_byte;
              out_last  <= 1'b0;
            end
          end
        end
        ST_UPDATE: begin
          j   <= '0;
          pv  <= 1'b0;
          sum <= '0;
          if (rescale) begin
            state <= ST_RESCALE;
          end else begin
            ctx   <= (MODEL_ORDER != 0) ? sym : '0;
            k     <= '0;
            state <= last ? ST_FLUSH : ST_FINISH;
          end
        end
        ST_RESCALE: begin
          // Halve every entry of the row, keeping a floor of one.
          j  <= j + 1'b1;
          pj <= j[SB-1:0];
          pv <= 1'b1;
          if (pv) begin
            sum <= sum_new;
            if (pj == LAST_SYM) begin
              ctx   <= (MODEL_ORDER != 0) ? sym : '0;
              k     <= '0;
              state <= last ? ST_FLUSH : ST_FINISH;
            end
          end
        end
        ST_FLUSH: begin
          if (k == 3'(FLUSH_BYTES)) begin
            low   <= '0;
            range <= RANGE_FULL;
            ctx   <= '0;
            state <= ST_FINISH;
          end else if (emit_ok) begin
            low        <= low << 8;
            k          <= k + 3'd1;
            hold_byte  <= low[31:24];
            hold_valid <= 1'b1;
            if (hold_valid) begin
              out_valid <= 1'b1;
              out_byte  <= hold_byte;
              out_last  <= 1'b0;
            end
          end
        end
        ST_FINISH: begin
          // The held byte is the request's final one.
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (can_push) begin
            out_valid  <= 1'b1;
            out_byte   <= hold_byte;
            out_last   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_renorm_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RENORM) |-> (k <= 3'(MAX_RENORM)))
    else $error("renormalization ran past its bound");
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (tot != '0))
    else $error("zero divisor in range division");
  a_final_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && hold_valid && can_push) |=> (out_valid && out_last))
    else $error("final byte not marked as last");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE) && !hold_valid)
    else $error("request taken while previous one unfinished");

endmodule

FILE: design/adaptive_context_range_encoder_core.sv
// Top level of the adaptive context range encoder: front queue plus coding engine.
// Depends on acre_pkg, acre_sym_if, acre_byte_if, acre_front and acre_engine.
//
//   Channel   Direction  Payload                 Request
//   sym_ch    in         symbol, is_last         one symbol to code
//   byte_ch   out        out_byte, last_of_run   one coded byte
//
// A symbol passes the engine's walk, divide, multiply, add, renormalize and update
// steps, one symbol at a time: the cumulative-frequency walk reads one table entry per
// cycle through the frequency RAM port, and the division produces one quotient bit per
// cycle. A row rescale runs when the total reaches its limit, and a final symbol adds a
// four-byte flush. After reset a clearing pass over all 2^(SYMBOL_BITS*(MODEL_ORDER+1))
// frequency entries fills the tables; no symbol is accepted until it ends. The two-entry
// input queue takes symbols until full while a stalled byte channel holds the engine.
module adaptive_context_range_encoder_core #(
  parameter int SYMBOL_BITS = acre_pkg::DEF_SYMBOL_BITS,
  parameter int MODEL_ORDER = acre_pkg::DEF_MODEL_ORDER
) (
  input  logic        clk,
  input  logic        rst,
  acre_sym_if.sink    sym_ch,
  acre_byte_if.source byte_ch
);
  import acre_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  pop;
  logic  clearing;

  acre_front #(.SYMBOL_BITS(SYMBOL_BITS)) u_front (
    .clk(clk), .rst(rst), .sym_ch(sym_ch), .clearing(clearing),
    .q_valid(q_valid), .q_item(q_item), .pop(pop)
  );

  acre_engine #(.SYMBOL_BITS(SYMBOL_BITS), .MODEL_ORDER(MODEL_ORDER)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .pop(pop),
    .clearing(clearing), .byte_ch(byte_ch)
  );

endmodule
